@@ rtl/core/ssr_pkg.sv @@
// Shared constants and types for the streaming substring replacer.
package ssr_pkg;

  localparam int MAX_PATTERN_DEF     = 8;
  localparam int MAX_REPLACEMENT_DEF = 8;

  // Number of result groups the output queue holds; a power of two.
  localparam int QUEUE_DEPTH = 4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_BYTES  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_LENGTH = 3'd3;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

endpackage

@@ rtl/core/ssr_cell.sv @@
// One window cell: holds a byte, compares it with its pattern byte, shifts towards the head.
module ssr_cell (
  input  logic              clk,
  input  ssr_pkg::cell_ctl_t ctl,
  input  logic              sel,
  input  logic [7:0]        in_byte,
  input  logic [7:0]        nb_byte,
  input  logic [7:0]        pat_byte,
  input  logic              active,
  output logic [7:0]        view_byte,
  output logic              match
);

  logic [7:0] held;

  assign view_byte = sel ? in_byte : held;
  assign match     = !active || (view_byte == pat_byte);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      held <= ctl.shift ? nb_byte : view_byte;
    end
  end

endmodule

@@ rtl/core/ssr_queue.sv @@
// Queue of result groups with a serialiser that hands out one word per cycle while the output is not stalled.
module ssr_queue #(
  parameter int SLOTS = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  logic [SLOTS*8-1:0]              push_data,
  input  logic [$clog2(SLOTS+1)-1:0]      push_count,
  input  logic                            push_last,
  output logic                            full,
  output logic                            dst_valid,
  input  logic                            dst_stall,
  output logic [7:0]                      out_byte,
  output logic                            out_valid,
  output logic                            out_last
);

  localparam int DEPTH = ssr_pkg::QUEUE_DEPTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(SLOTS + 1);
  localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [SLOTS*8-1:0] data [DEPTH];
  logic [CW-1:0]      cnt  [DEPTH];
  logic               lst  [DEPTH];

  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   used;
  logic [SW-1:0] slot;

  logic [CW-1:0] head_cnt;
  logic          end_of_group;
  logic          take;
  logic          pop;
  logic          put;

  assign head_cnt     = cnt[rd_ptr];
  assign end_of_group = (head_cnt == '0) || ((CW'(slot) + CW'(1)) == head_cnt);
  assign dst_valid    = (used != '0);
  assign full         = (used == (AW+1)'(DEPTH));
  assign take         = dst_valid && !dst_stall;
  assign pop          = take && end_of_group;
  assign put          = push && !full;

  assign out_valid = (head_cnt != '0);
  assign out_byte  = out_valid ? data[rd_ptr][slot*8 +: 8] : 8'h00;
  assign out_last  = lst[rd_ptr] && end_of_group;

  always_ff @(posedge clk) begin
    if (put) begin
      data[wr_ptr] <= push_data;
      cnt[wr_ptr]  <= push_count;
      lst[wr_ptr]  <= push_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      used   <= '0;
      slot   <= '0;
    end else begin
      if (put) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (take) begin
        if (end_of_group) begin
          rd_ptr <= rd_ptr + AW'(1);
          slot   <= '0;
        end else begin
          slot <= slot + SW'(1);
        end
      end
      if (put && !pop) begin
        used <= used + (AW+1)'(1);
      end else if (pop && !put) begin
        used <= used - (AW+1)'(1);
      end
    end
  end

endmodule

@@ rtl/core/stream_substring_replace.sv @@
// Top level of the streaming substring replacer: window cells, match logic and output queue.
// A byte's results go into the output queue when the byte is taken and are offered from there.
// Throughput: one byte per cycle while each byte yields at most one word and no stall holds
// the output; a four-group queue absorbs replacement and flush bursts.
// Reset clears the window fill, the queue and the registers (pattern length one, others zero).
module stream_substring_replace #(
  parameter int MAX_PATTERN     = ssr_pkg::MAX_PATTERN_DEF,
  parameter int MAX_REPLACEMENT = ssr_pkg::MAX_REPLACEMENT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ssr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ssr_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           src_valid,
  output logic                           src_stall,
  input  logic [7:0]                     in_byte,
  input  logic                           is_last,
  output logic                           dst_valid,
  input  logic                           dst_stall,
  output logic [7:0]                     out_byte,
  output logic                           out_valid,
  output logic                           out_last
);

  localparam int SLOTS = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN :
                         ((MAX_REPLACEMENT > 0) ? MAX_REPLACEMENT : 1);
  localparam int FW    = $clog2(MAX_PATTERN + 1);
  localparam int CW    = $clog2(SLOTS + 1);

  logic [63:0] pattern_bytes;
  logic [3:0]  pattern_length;
  logic [63:0] replacement_bytes;
  logic [3:0]  replacement_length;
  logic [FW-1:0] fill;
  logic [FW-1:0] fill_next;

  logic [3:0] plen;
  logic [3:0] rlen;
  logic [3:0] fill4;
  logic       accept;
  logic       cfg_write;
  logic       full_win;
  logic       hit;
  logic       push;
  logic       q_full;
  logic [CW-1:0]      grp_count;
  logic [SLOTS*8-1:0] grp_data;
  ssr_pkg::cell_ctl_t cell_ctl;

  logic [7:0]             view [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] match;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign src_stall = q_full;
  assign accept    = src_valid && !src_stall;

  assign plen = (pattern_length == 4'd0) ? 4'd1 :
                (pattern_length > 4'(MAX_PATTERN)) ? 4'(MAX_PATTERN) : pattern_length;
  assign rlen = (replacement_length > 4'(MAX_REPLACEMENT)) ? 4'(MAX_REPLACEMENT) :
                replacement_length;

  assign fill4    = 4'(fill);
  assign full_win = ((fill4 + 4'd1) == plen);
  assign hit      = full_win && (&match);

  assign cell_ctl.load  = accept;
  assign cell_ctl.shift = full_win && !hit;

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    logic [7:0] nb;
    if (k + 1 < MAX_PATTERN) begin : g_mid
      assign nb = view[k+1];
    end else begin : g_end
      assign nb = 8'h00;
    end
    ssr_cell u_cell (
      .clk       (clk),
      .ctl       (cell_ctl),
      .sel       (fill4 == 4'(k)),
      .in_byte   (in_byte),
      .nb_byte   (nb),
      .pat_byte  (pattern_bytes[k*8 +: 8]),
      .active    (4'(k) < plen),
      .view_byte (view[k]),
      .match     (match[k])
    );
  end

  for (genvar i = 0; i < SLOTS; i++) begin : g_grp
    if (i < MAX_PATTERN) begin : g_win
      assign grp_data[i*8 +: 8] = hit ? replacement_bytes[i*8 +: 8] : view[i];
    end else begin : g_rep
      assign grp_data[i*8 +: 8] = hit ? replacement_bytes[i*8 +: 8] : 8'h00;
    end
  end

  assign grp_count = hit ? CW'(rlen) : (is_last ? CW'(fill4 + 4'd1) : CW'(full_win));
  assign push      = accept && ((grp_count != '0) || is_last);

  always_comb begin
    fill_next = fill;
    if (cfg_write && (cfg_index == ssr_pkg::REG_PATTERN_LENGTH)) begin
      fill_next = '0;
    end else if (accept) begin
      if (is_last || hit) begin
        fill_next = '0;
      end else if (!full_win) begin
        fill_next = FW'(fill4 + 4'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes      <= '0;
      pattern_length     <= 4'd1;
      replacement_bytes  <= '0;
      replacement_length <= '0;
      fill               <= '0;
    end else begin
      fill <= fill_next;
      if (cfg_write) begin
        unique case (cfg_index)
          ssr_pkg::REG_PATTERN_BYTES:      pattern_bytes      <= cfg_data;
          ssr_pkg::REG_PATTERN_LENGTH:     pattern_length     <= cfg_data[3:0];
          ssr_pkg::REG_REPLACEMENT_BYTES:  replacement_bytes  <= cfg_data;
          ssr_pkg::REG_REPLACEMENT_LENGTH: replacement_length <= cfg_data[3:0];
          default: ;
        endcase
      end
    end
  end

  ssr_queue #(
    .SLOTS (SLOTS)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (grp_data),
    .push_count (grp_count),
    .push_last  (is_last),
    .full       (q_full),
    .dst_valid  (dst_valid),
    .dst_stall  (dst_stall),
    .out_byte   (out_byte),
    .out_valid  (out_valid),
    .out_last   (out_last)
  );

endmodule

@@ rtl/core/ssr_checker.sv @@
// Port-level checks for the streaming substring replacer, bound to the top level.
module ssr_checker (
  input logic       clk,
  input logic       rst,
  input logic       dst_valid,
  input logic       dst_stall,
  input logic [7:0] out_byte,
  input logic       out_valid,
  input logic       out_last
);

  // A stalled word stays on offer unchanged.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    dst_valid && dst_stall |=> dst_valid && $stable(out_byte) && $stable(out_valid)
      && $stable(out_last))
    else $error("stalled output word changed");

  // A word without a byte only ever closes a text.
  a_marker_last: assert property (@(posedge clk) disable iff (rst)
    dst_valid && !out_valid |-> out_last)
    else $error("bare end marker without last flag");

  // A bare end marker carries a zero byte.
  a_marker_zero: assert property (@(posedge clk) disable iff (rst)
    dst_valid && !out_valid |-> (out_byte == 8'h00))
    else $error("bare end marker with non-zero byte");

  // Nothing is offered in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !dst_valid)
    else $error("output word offered straight after reset");

endmodule

bind stream_substring_replace ssr_checker u_ssr_checker (
  .clk       (clk),
  .rst       (rst),
  .dst_valid (dst_valid),
  .dst_stall (dst_stall),
  .out_byte  (out_byte),
  .out_valid (out_valid),
  .out_last  (out_last)
);
